/* sv/sss_pkg.sv */
package sss_pkg;

  localparam int MAX_ANGLE_DEF = 180;

  localparam int ANGLE_W = 8;
  localparam int WAIT_W  = 16;
  localparam int CFG_W   = 16;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_UP    = 3'd1;
  localparam logic [2:0] MODE_DOWN  = 3'd2;
  localparam logic [2:0] MODE_SET   = 3'd3;
  localparam logic [2:0] MODE_PLACE = 3'd4;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_UP     = 2'd1;
  localparam logic [1:0] EV_DOWN   = 2'd2;
  localparam logic [1:0] EV_FINISH = 2'd3;

  localparam logic CFG_STRIDE = 1'b0;
  localparam logic CFG_DWELL  = 1'b1;

  localparam logic [ANGLE_W-1:0] STRIDE_RST = 8'd180;
  localparam logic [WAIT_W-1:0]  DWELL_RST  = 16'd0;

  typedef struct packed {
    logic [2:0]         mode;
    logic [ANGLE_W-1:0] target;
  } sss_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] drive_position;
    logic [1:0]         event_kind;
    logic [ANGLE_W-1:0] event_position;
    logic [ANGLE_W-1:0] destination;
    logic               busy_res;
  } sss_out_t;

endpackage

/* sv/sss_core.sv */
module sss_core import sss_pkg::*; #(
  parameter int MAX_ANGLE = MAX_ANGLE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  sss_in_t             item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output sss_out_t            res
);

  localparam logic [ANGLE_W-1:0] MAX_A = ANGLE_W'(MAX_ANGLE);

  logic [ANGLE_W-1:0] stride_r, stride_nxt;
  logic [WAIT_W-1:0]  dwell_r, dwell_nxt;
  logic [ANGLE_W-1:0] angle_now_r, angle_now_nxt;
  logic [ANGLE_W-1:0] angle_goal_r, angle_goal_nxt;
  logic               wait_r, wait_nxt;
  logic [WAIT_W-1:0]  wait_count_r, wait_count_nxt;

  logic [ANGLE_W:0]   sum_up;
  logic [ANGLE_W-1:0] n_up;
  logic [ANGLE_W-1:0] diff_dn;
  logic [ANGLE_W-1:0] n_dn;
  logic [ANGLE_W:0]   goal_up;
  logic [ANGLE_W-1:0] goal_dn;
  logic [ANGLE_W-1:0] tgt_sat;
  logic [1:0]         ev;
  logic [ANGLE_W-1:0] evpos;
  logic               decide;

  always_comb begin
    sum_up  = {1'b0, angle_now_r} + {1'b0, stride_r};
    n_up    = (sum_up > {1'b0, angle_goal_r}) ? angle_goal_r : sum_up[ANGLE_W-1:0];
    diff_dn = angle_now_r - angle_goal_r;
    n_dn    = (stride_r >= diff_dn) ? angle_goal_r : angle_now_r - stride_r;
    goal_up = {1'b0, angle_goal_r} + {1'b0, stride_r};
    goal_dn = (stride_r >= angle_goal_r) ? '0 : angle_goal_r - stride_r;
    tgt_sat = (item.target > MAX_A) ? MAX_A : item.target;
  end

  always_comb begin
    stride_nxt     = stride_r;
    dwell_nxt      = dwell_r;
    angle_now_nxt  = angle_now_r;
    angle_goal_nxt = angle_goal_r;
    wait_nxt       = wait_r;
    wait_count_nxt = wait_count_r;
    ev             = EV_NONE;
    evpos          = '0;
    decide         = 1'b0;
    if (fire) begin
      unique case (item.mode)
        MODE_TICK: begin
          if (wait_r && wait_count_r != '0) begin
            wait_count_nxt = wait_count_r - 1'b1;
          end else begin
            decide = 1'b1;
          end
        end
        MODE_UP: begin
          angle_goal_nxt = (goal_up > {1'b0, MAX_A}) ? MAX_A : goal_up[ANGLE_W-1:0];
        end
        MODE_DOWN: begin
          angle_goal_nxt = goal_dn;
        end
        MODE_SET: begin
          angle_goal_nxt = tgt_sat;
        end
        MODE_PLACE: begin
          angle_now_nxt  = tgt_sat;
          angle_goal_nxt = tgt_sat;
          wait_nxt       = 1'b0;
          wait_count_nxt = '0;
        end
        default: begin
        end
      endcase
      if (decide) begin
        if (angle_goal_r > angle_now_r) begin
          angle_now_nxt  = n_up;
          wait_nxt       = 1'b1;
          wait_count_nxt = dwell_r;
          ev             = EV_UP;
          evpos          = angle_now_r;
        end else if (angle_goal_r < angle_now_r) begin
          angle_now_nxt  = n_dn;
          wait_nxt       = 1'b1;
          wait_count_nxt = dwell_r;
          ev             = EV_DOWN;
          evpos          = angle_now_r;
        end else begin
          wait_nxt = 1'b0;
          if (wait_r) begin
            ev    = EV_FINISH;
            evpos = angle_now_r;
          end
        end
      end
    end
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_STRIDE: stride_nxt = cfg_data[ANGLE_W-1:0];
        CFG_DWELL: begin
          dwell_nxt      = cfg_data[WAIT_W-1:0];
          wait_count_nxt = cfg_data[WAIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.drive_position = angle_now_nxt;
    res.event_kind     = ev;
    res.event_position = evpos;
    res.destination    = angle_goal_nxt;
    res.busy_res       = wait_nxt || (angle_now_nxt != angle_goal_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r     <= STRIDE_RST;
      dwell_r      <= DWELL_RST;
      angle_now_r  <= '0;
      angle_goal_r <= '0;
      wait_r       <= 1'b0;
      wait_count_r <= '0;
    end else begin
      stride_r     <= stride_nxt;
      dwell_r      <= dwell_nxt;
      angle_now_r  <= angle_now_nxt;
      angle_goal_r <= angle_goal_nxt;
      wait_r       <= wait_nxt;
      wait_count_r <= wait_count_nxt;
    end
  end

`ifndef SYNTH
  a_step_starts_wait: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.event_kind == EV_UP || res.event_kind == EV_DOWN) |=> wait_r)
    else $error("step did not start a wait");

  a_finish_at_goal: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.event_kind == EV_FINISH |-> res.drive_position == res.destination)
    else $error("finished away from destination");

  a_quiet_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire && !cfg_we |=> $stable(angle_now_r) && $stable(angle_goal_r)
      && $stable(wait_count_r) && $stable(wait_r))
    else $error("state moved without a transfer");

  a_goal_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> angle_goal_r <= MAX_A)
    else $error("destination out of range");
`endif

endmodule

/* sv/servo_slew_stepper.sv */
// channel | direction | payload   | handshake
// in_     | input     | sss_in_t  | in_valid / in_ready
// out_    | output    | sss_out_t | out_valid / out_ready
// cfg_    | input     | index+data| cfg_we, no wait
// one item a cycle unless a stalled result holds the pipe; result valid once the item has left the input register
// an input register then the step logic into the result register
// rst_n synchronous: stride 180, dwell 0, angle, goal, wait cleared
// a stalled result holds the pipe; the input register still takes one item
module servo_slew_stepper import sss_pkg::*; #(
  parameter int MAX_ANGLE = MAX_ANGLE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sss_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sss_out_t         out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic     in_valid_r;
  sss_in_t  in_r;
  logic     out_valid_r;
  sss_out_t out_r;
  logic     advance;
  logic     fire;
  sss_out_t res;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  sss_core #(
    .MAX_ANGLE(MAX_ANGLE)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (in_r),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_r))
    else $error("pending item lost while stalled");

  a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed item produced no result");

  a_no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_valid_r |=> !out_valid_r)
    else $error("result without an item");
`endif

endmodule
